// File: hdl/smem_pkg.sv
// shared sizes, operation codes and error codes for the segmented memory
`default_nettype none
package smem_pkg;
  localparam int unsigned SEGMENTS          = 64;
  localparam int unsigned WORDS_PER_SEGMENT = 256;

  localparam logic [2:0] OP_MAP      = 3'd0;
  localparam logic [2:0] OP_UNMAP    = 3'd1;
  localparam logic [2:0] OP_LOAD     = 3'd2;
  localparam logic [2:0] OP_STORE    = 3'd3;
  localparam logic [2:0] OP_LOADPROG = 3'd4;
  localparam logic [2:0] OP_CREATE0  = 3'd5;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_BAD    = 2'd1;
  localparam logic [1:0] ERR_NO_ID  = 2'd2;
endpackage
`default_nettype wire

// File: hdl/segmented_memory_with_id_reuse.sv
// top level of the segmented word memory with identifier reuse
`default_nettype none
// channel | dir | ports                                          | handshake
// cmd     | in  | operation_i segment_id_i offset_i value_i      | start & !busy
//         |     | length_i                                       |
// result  | out | read_data_o new_segment_id_o next_pc_o         | done, one cycle
//         |     | program_length_o error_o                       |
// store, unmap, rejected ops, load program of segment zero: length table read state, then done state
// load: one more state, for the registered word read
// map and create: a fill state writes one zeroed word per cycle on the word ram port
// load program: each copied word is a ram read (S_CRD) then a write (S_CWR)
// reset clears mapped bits, free queue and counters; lengths and words stay undefined
// results cannot be stalled: done is a single-cycle strobe
module segmented_memory_with_id_reuse (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation_i,
  input  wire logic [5:0]  segment_id_i,
  input  wire logic [7:0]  offset_i,
  input  wire logic [31:0] value_i,
  input  wire logic [8:0]  length_i,
  output logic             done,
  output logic [31:0]      read_data_o,
  output logic [5:0]       new_segment_id_o,
  output logic [7:0]       next_pc_o,
  output logic [8:0]       program_length_o,
  output logic [1:0]       error_o
);
  import smem_pkg::*;

  localparam int unsigned SW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned OW  = (WORDS_PER_SEGMENT > 1) ? $clog2(WORDS_PER_SEGMENT) : 1;
  localparam int unsigned LW  = $clog2(WORDS_PER_SEGMENT + 1);
  localparam int unsigned CW  = $clog2(SEGMENTS + 1);
  localparam int unsigned AW  = SW + OW;
  localparam int unsigned DEP = SEGMENTS * (2 ** OW);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEN   = 3'd1; // length table read is back
  localparam logic [2:0] S_WORD  = 3'd2; // load data is back
  localparam logic [2:0] S_FILL  = 3'd3; // zero fill, one word a cycle
  localparam logic [2:0] S_CRD   = 3'd4; // copy: read source word
  localparam logic [2:0] S_CWR   = 3'd5; // copy: write to segment zero
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  // latched command
  logic [2:0]  op_q;
  logic [5:0]  id_q;
  logic [7:0]  off_q;
  logic [31:0] val_q;
  logic [8:0]  len_q;

  // length table: small memory, registered read
  logic [LW-1:0] len_mem [SEGMENTS];
  logic [LW-1:0] len_rd_q;
  logic          len_we;
  logic [SW-1:0] len_waddr;
  logic [LW-1:0] len_wdata;
  logic [SW-1:0] len_raddr;

  // mapped bits in flip-flops so reset clears them at once
  logic [SEGMENTS-1:0] mapped_q, mapped_d;

  // free identifier queue, head entry read through a register
  logic [SW-1:0] fq_mem [SEGMENTS];
  logic [SW-1:0] fq_head_q, fq_head_d;
  logic [CW-1:0] fq_cnt_q, fq_cnt_d;
  logic [SW-1:0] fq_head_rd_q;
  logic [SW-1:0] fq_head_val;
  logic          fq_we;
  logic [SW-1:0] fq_waddr;
  logic [CW:0]   fq_tail_sum;

  logic [CW-1:0] highest_q, highest_d;
  logic [8:0]    psize_q, psize_d;

  // fill and copy counter
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] tgt_q, tgt_d;
  logic [SW-1:0] seg_q, seg_d;

  // result registers
  logic        done_q, done_d;
  logic [31:0] rd_q, rd_d;
  logic [5:0]  nid_q, nid_d;
  logic [7:0]  npc_q, npc_d;
  logic [1:0]  err_q, err_d;

  // word ram
  logic          w_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [31:0]   w_wdata, w_rdata;

  logic          id_in_range;
  logic          seg_ok;
  logic          len_too_big;
  logic          off_ok;
  logic [SW-1:0] id_s;
  logic [OW-1:0] off_s;
  logic [OW-1:0] cnt_s;

  smem_word_ram #(.DEPTH(DEP), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // queue head and writes settle before the next accept
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rd_q <= len_mem[len_raddr];
    if (fq_we) begin
      fq_mem[fq_waddr] <= id_q[SW-1:0];
    end
    fq_head_rd_q <= fq_mem[fq_head_q];
  end

  assign fq_head_val = fq_head_rd_q;

  assign id_s        = SW'(id_q);
  assign off_s       = OW'(off_q);
  assign cnt_s       = cnt_q[OW-1:0];
  assign id_in_range = (32'(id_q) < SEGMENTS);
  assign seg_ok      = id_in_range && mapped_q[id_s];
  assign len_too_big = (32'(len_q) > WORDS_PER_SEGMENT);
  // unmapped entries may hold stale lengths, seg_ok guards that
  assign off_ok      = (32'(off_q) < 32'(len_rd_q));
  assign fq_tail_sum = (CW+1)'(fq_head_q) + (CW+1)'(fq_cnt_q);

  // length read address follows the command while idle
  assign len_raddr = (state_q == S_IDLE) ? SW'(segment_id_i) : id_s;

  always_comb begin
    state_d   = state_q;
    mapped_d  = mapped_q;
    fq_head_d = fq_head_q;
    fq_cnt_d  = fq_cnt_q;
    highest_d = highest_q;
    psize_d   = psize_q;
    cnt_d     = cnt_q;
    tgt_d     = tgt_q;
    seg_d     = seg_q;
    done_d    = 1'b0;
    rd_d      = rd_q;
    nid_d     = nid_q;
    npc_d     = npc_q;
    err_d     = err_q;
    len_we    = 1'b0;
    len_waddr = id_s;
    len_wdata = '0;
    fq_we     = 1'b0;
    // tail wraps past the last queue slot
    fq_waddr  = (fq_tail_sum >= (CW+1)'(SEGMENTS)) ?
                SW'(fq_tail_sum - (CW+1)'(SEGMENTS)) : SW'(fq_tail_sum);
    w_we      = 1'b0;
    w_waddr   = {seg_q, cnt_s};
    w_wdata   = '0;
    w_raddr   = {id_s, off_s};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        rd_d  = '0;
        nid_d = '0;
        npc_d = '0;
        err_d = ERR_OK;
        cnt_d = '0;
        state_d = S_DONE;
        case (op_q)
          OP_MAP: begin
            if (len_too_big) begin
              err_d = ERR_BAD;
            end else if (fq_cnt_q != '0) begin
              seg_d     = fq_head_val;
              nid_d     = 6'(fq_head_val);
              fq_head_d = (fq_head_q == SW'(SEGMENTS - 1)) ? '0 : fq_head_q + 1'b1;
              fq_cnt_d  = fq_cnt_q - 1'b1;
              tgt_d     = LW'(len_q);
              state_d   = S_FILL;
            end else if (32'(highest_q) + 1 < SEGMENTS) begin
              highest_d = highest_q + 1'b1;
              seg_d     = SW'(highest_q + 1'b1);
              nid_d     = 6'(highest_q + 1'b1);
              tgt_d     = LW'(len_q);
              state_d   = S_FILL;
            end else begin
              err_d = ERR_NO_ID;
            end
          end
          OP_CREATE0: begin
            if (len_too_big) begin
              err_d = ERR_BAD;
            end else begin
              seg_d   = '0;
              tgt_d   = LW'(len_q);
              state_d = S_FILL;
            end
          end
          OP_UNMAP: begin
            if (!seg_ok) begin
              err_d = ERR_BAD;
            end else begin
              mapped_d[id_s] = 1'b0;
              len_we = 1'b1;
              if (id_q != '0 && 32'(fq_cnt_q) < SEGMENTS) begin
                fq_we    = 1'b1;
                fq_cnt_d = fq_cnt_q + 1'b1;
              end
            end
          end
          OP_LOAD, OP_STORE: begin
            if (!seg_ok || !off_ok) begin
              err_d = ERR_BAD;
            end else if (op_q == OP_LOAD) begin
              state_d = S_WORD;
            end else begin
              w_we    = 1'b1;
              w_waddr = {id_s, off_s};
              w_wdata = val_q;
            end
          end
          OP_LOADPROG: begin
            if (id_q == '0) begin
              npc_d = off_q;
            end else if (!seg_ok) begin
              err_d = ERR_BAD;
            end else begin
              npc_d = off_q;
              tgt_d = len_rd_q;
              state_d = S_CRD;
            end
          end
          default: ;
        endcase
      end
      S_WORD: begin
        rd_d    = w_rdata;
        state_d = S_DONE;
      end
      S_FILL: begin
        if (cnt_q == tgt_q) begin
          len_we    = 1'b1;
          len_waddr = seg_q;
          len_wdata = tgt_q;
          mapped_d[seg_q] = 1'b1;
          if (op_q == OP_CREATE0) begin
            psize_d = 9'(tgt_q);
          end
          state_d = S_DONE;
        end else begin
          w_we    = 1'b1;
          w_waddr = {seg_q, cnt_s};
          cnt_d   = cnt_q + 1'b1;
        end
      end
      S_CRD: begin
        // source and destination share the index, and each word is read before its write
        w_raddr = {id_s, cnt_s};
        if (cnt_q == tgt_q) begin
          len_we    = 1'b1;
          len_waddr = '0;
          len_wdata = tgt_q;
          mapped_d[0] = 1'b1;
          psize_d   = 9'(tgt_q);
          state_d   = S_DONE;
        end else begin
          state_d = S_CWR;
        end
      end
      S_CWR: begin
        w_we    = 1'b1;
        w_waddr = {{SW{1'b0}}, cnt_s};
        w_wdata = w_rdata;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_CRD;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mapped_q  <= '0;
      fq_head_q <= '0;
      fq_cnt_q  <= '0;
      highest_q <= '0;
      psize_q   <= '0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      mapped_q  <= mapped_d;
      fq_head_q <= fq_head_d;
      fq_cnt_q  <= fq_cnt_d;
      highest_q <= highest_d;
      psize_q   <= psize_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q  <= operation_i;
      id_q  <= segment_id_i;
      off_q <= offset_i;
      val_q <= value_i;
      len_q <= length_i;
    end
    tgt_q <= tgt_d;
    seg_q <= seg_d;
    rd_q  <= rd_d;
    nid_q <= nid_d;
    npc_q <= npc_d;
    err_q <= err_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done             = done_q;
  assign read_data_o      = rd_q;
  assign new_segment_id_o = nid_q;
  assign next_pc_o        = npc_q;
  assign program_length_o = psize_q;
  assign error_o          = err_q;

  // free queue never holds more than the identifier space
  a_fq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fq_cnt_q) <= SEGMENTS) else $error("free queue overflow");

  // a result strobe always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("done outside idle");

  // fill never passes its target
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> cnt_q <= tgt_q) else $error("fill overrun");

  // a start while idle always raises busy next
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

// File: hdl/smem_word_ram.sv
// word store of all segments, one write and one registered read port
`default_nettype none
module smem_word_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
